### src/wtss_pkg.sv
// Shared types and constants of the wave-terrain spline sampler.
`timescale 1ns / 1ps

package wtss_pkg;

    // Fixed field widths
    localparam int ROW_W    = 3;
    localparam int COL_W    = 10;
    localparam int WORD_W   = 15;
    localparam int CV_W     = 12;
    localparam int SAMPLE_W = 12;
    localparam int IDX_W    = 3;

    // Horner accumulator width and spline gain
    localparam int T_W = 28;
    localparam logic signed [20:0] SPLINE_K = 21'sd699051;

    // Job queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_X_OFFSET     = 3'd0;
    localparam logic [IDX_W-1:0] REG_Y_OFFSET     = 3'd1;
    localparam logic [IDX_W-1:0] REG_X_WRAP       = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_WRAP       = 3'd3;
    localparam logic [IDX_W-1:0] REG_COMBINE_MODE = 3'd4;

    typedef enum logic [1:0] {
        CMB_PRODUCT = 2'd0,
        CMB_SUM     = 2'd1,
        CMB_DIFF    = 2'd2,
        CMB_PHASE   = 2'd3
    } t_comb;

    typedef struct packed {
        logic [CV_W-1:0] x_offset;
        logic [CV_W-1:0] y_offset;
        logic            x_wrap;
        logic            y_wrap;
        t_comb           combine_mode;
    } t_cfg;

    // One classified item on its way to the back end
    typedef struct packed {
        logic              is_wr;
        logic              wr_ok;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] xi;
        logic [WORD_W-1:0] yi;
        logic [CV_W-1:0]   z;
    } t_job;

endpackage

### src/wtss_ifs.sv
// Channel interfaces: input items, result samples and register writes.
`timescale 1ns / 1ps

interface wtss_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [2:0]  table_row;
    logic [9:0]  table_col;
    logic [14:0] table_data;
    logic [11:0] x_cv;
    logic [11:0] y_cv;
    logic [11:0] z_morph;

    modport source (output valid, mode, table_row, table_col, table_data, x_cv, y_cv,
                    z_morph, input ready);
    modport sink (input valid, mode, table_row, table_col, table_data, x_cv, y_cv,
                  z_morph, output ready);
endinterface

interface wtss_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] sample;

    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

interface wtss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/wave_terrain_spline_sampler_unit.sv
// Top level of the wave-terrain spline sampler: registers, front, queue, back.
//
//  channel  dir  beat                                      handshake
//  i_in     in   mode, table_row/col/data, x/y_cv, z_morph  valid/ready
//  o_out    out  sample                                    valid/ready
//  i_cfg    in   index, data                               valid/ready
//
// A table write is stored in the back end straight from the queue head; a sample is
// built by the per-axis sequence: 6 dual-port table reads, 6 Horner steps of the
// shared spline multiplier and a clamp, twice, plus combine.
// The front takes a beat every cycle while the 4-entry queue has room.
// Reset is synchronous, active low; the table is undefined until written.
// A finished sample waits in the output register while the next item proceeds.
`timescale 1ns / 1ps

module wave_terrain_spline_sampler_unit #(
    parameter int FAMILY_ROWS = 5,
    parameter int ROW_LENGTH  = 517
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wtss_in_if.sink     i_in,
    wtss_cfg_if.sink    i_cfg,
    wtss_out_if.source  o_out
);

    wtss_pkg::t_cfg r_cfg;
    wtss_pkg::t_job front_job;
    wtss_pkg::t_job head_job;
    logic           push;
    logic           full;
    logic           head_valid;
    logic           pop;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_offset     <= 12'd2048;
            r_cfg.y_offset     <= 12'd2048;
            r_cfg.x_wrap       <= 1'b0;
            r_cfg.y_wrap       <= 1'b0;
            r_cfg.combine_mode <= wtss_pkg::CMB_PRODUCT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                wtss_pkg::REG_X_OFFSET:     r_cfg.x_offset <= i_cfg.data;
                wtss_pkg::REG_Y_OFFSET:     r_cfg.y_offset <= i_cfg.data;
                wtss_pkg::REG_X_WRAP:       r_cfg.x_wrap   <= i_cfg.data[0];
                wtss_pkg::REG_Y_WRAP:       r_cfg.y_wrap   <= i_cfg.data[0];
                wtss_pkg::REG_COMBINE_MODE:
                    r_cfg.combine_mode <= wtss_pkg::t_comb'(i_cfg.data[1:0]);
                default: ;
            endcase
        end
    end

    wtss_front #(
        .FAMILY_ROWS (FAMILY_ROWS),
        .ROW_LENGTH  (ROW_LENGTH)
    ) u_front (
        .i_in   (i_in),
        .i_cfg  (r_cfg),
        .i_full (full),
        .o_push (push),
        .o_job  (front_job)
    );

    wtss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    wtss_back #(
        .FAMILY_ROWS (FAMILY_ROWS),
        .ROW_LENGTH  (ROW_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_job_pop   (pop),
        .o_out       (o_out)
    );

endmodule

### src/wtss_front.sv
// Front end: takes input beats, maps the CVs to table indexes, checks writes.
`timescale 1ns / 1ps

module wtss_front #(
    parameter int FAMILY_ROWS = 5,
    parameter int ROW_LENGTH  = 517
) (
    wtss_in_if.sink           i_in,
    input  wtss_pkg::t_cfg    i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output wtss_pkg::t_job    o_job
);

    // Position 8*(off-2048-cv), folded or wrapped to 15 bits
    function automatic logic [14:0] axis_index(input logic [11:0] cv,
                                               input logic [11:0] off,
                                               input logic        wrap);
        logic signed [13:0] d;
        logic [14:0]        low;
        d   = $signed({2'b00, off}) - 14'sd2048 - $signed({2'b00, cv});
        low = {d[11:0], 3'b000};
        if (!wrap && d[12]) begin
            return ~low;
        end
        return low;
    endfunction

    // Accept whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Classify the beat
    always_comb begin
        o_job.is_wr = !i_in.mode;
        o_job.wr_ok = (int'(i_in.table_row) < FAMILY_ROWS) &&
                      (int'(i_in.table_col) < ROW_LENGTH);
        o_job.row   = i_in.table_row;
        o_job.col   = i_in.table_col;
        o_job.data  = i_in.table_data;
        o_job.xi    = axis_index(i_in.x_cv, i_cfg.x_offset, i_cfg.x_wrap);
        o_job.yi    = axis_index(i_in.y_cv, i_cfg.y_offset, i_cfg.y_wrap);
        o_job.z     = i_in.z_morph;
    end

endmodule

### src/wtss_queue.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module wtss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wtss_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output wtss_pkg::t_job o_job
);

    wtss_pkg::t_job                r_buf [wtss_pkg::Q_DEPTH];
    logic [wtss_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [wtss_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [wtss_pkg::Q_CNT_W-1:0]  r_count;
    logic                          pop_ok;

    function automatic logic [wtss_pkg::Q_CNT_W-1:0] Q_CNT_1(input logic b);
        return {{(wtss_pkg::Q_CNT_W-1){1'b0}}, b};
    endfunction

    assign o_full  = (r_count == wtss_pkg::Q_CNT_W'(wtss_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_buf[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;

    // Store incoming beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_1(i_push) - Q_CNT_1(pop_ok);
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wtss_pkg::Q_CNT_W'(wtss_pkg::Q_DEPTH))
        else $error("queue occupancy above depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");
`endif

endmodule

### src/wtss_back.sv
// Back end: wavetable store, morph interpolation, quintic spline and combine.
`timescale 1ns / 1ps

module wtss_back #(
    parameter int FAMILY_ROWS = 5,
    parameter int ROW_LENGTH  = 517
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wtss_pkg::t_cfg i_cfg,
    input  logic           i_job_valid,
    input  wtss_pkg::t_job i_job,
    output logic           o_job_pop,
    wtss_out_if.source     o_out
);

    localparam int DEPTH = FAMILY_ROWS * ROW_LENGTH;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_SPL   = 7'b0001000,
        S_FIN   = 7'b0010000,
        S_SETY  = 7'b0100000,
        S_COMB  = 7'b1000000
    } t_state;

    logic [14:0]                   r_mem [DEPTH];
    t_state                        r_state;
    wtss_pkg::t_job                r_job;
    logic                          r_pass;
    logic [8:0]                    r_col;
    logic [15:0]                   r_pf;
    logic [1:0]                    r_fam;
    logic [15:0]                   r_mf;
    logic [2:0]                    r_k;
    logic [2:0]                    r_step;
    logic [14:0]                   r_qa;
    logic [14:0]                   r_qb;
    logic                          r_za;
    logic                          r_zb;
    logic                          r_rd_v;
    logic [2:0]                    r_rd_k;
    logic signed [16:0]            r_s [6];
    logic signed [wtss_pkg::T_W-1:0] r_t;
    logic [14:0]                   r_xs;
    logic [14:0]                   r_ys;
    logic                          r_out_valid;
    logic [11:0]                   r_sample;

    logic [9:0]                    colk;
    logic                          za_c;
    logic                          zb_c;
    logic [AW-1:0]                 addr_a;
    logic [AW-1:0]                 addr_b;
    logic [AW-1:0]                 wr_addr;
    logic                          wr_fire;
    logic [14:0]                   a_w;
    logic [14:0]                   b_w;
    logic signed [16:0]            diff;
    logic signed [33:0]            ip;
    logic signed [16:0]            s_new;
    logic signed [wtss_pkg::T_W-1:0] coef;
    logic signed [44:0]            qp;
    logic signed [wtss_pkg::T_W-1:0] t_new;
    logic signed [48:0]            kp;
    logic signed [25:0]            fin;
    logic [14:0]                   fin_clamp;
    logic [24:0]                   phy;
    logic [11:0]                   morph;
    logic [29:0]                   prod;
    logic [15:0]                   sum;
    logic signed [15:0]            dxy;
    logic [11:0]                   comb;
    logic                          out_free;

    // Table write straight from the queue head
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign wr_fire   = o_job_pop && i_job.is_wr && i_job.wr_ok;
    assign wr_addr   = AW'(i_job.row) * AW'(ROW_LENGTH) + AW'(i_job.col);

    // Neighbour addresses of two adjacent families; out-of-range reads as zero
    assign colk   = {1'b0, r_col} + 10'(r_k);
    assign za_c   = (int'(r_fam) >= FAMILY_ROWS) || (int'(colk) >= ROW_LENGTH);
    assign zb_c   = (int'(r_fam) + 1 >= FAMILY_ROWS) || (int'(colk) >= ROW_LENGTH);
    assign addr_a = za_c ? '0 : AW'(r_fam) * AW'(ROW_LENGTH) + AW'(colk);
    assign addr_b = zb_c ? '0 : addr_a + AW'(ROW_LENGTH);

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[wr_addr] <= i_job.data;
        end
        if (r_state == S_READ) begin
            r_qa <= r_mem[addr_a];
            r_qb <= r_mem[addr_b];
        end
    end

    // Morph blend of the two read words
    assign a_w   = r_za ? '0 : r_qa;
    assign b_w   = r_zb ? '0 : r_qb;
    assign diff  = $signed({2'b00, b_w}) - $signed({2'b00, a_w});
    assign ip    = diff * $signed({1'b0, r_mf});
    assign s_new = $signed({2'b00, a_w}) + $signed(ip[32:16]);

    // Spline polynomial coefficient for the current Horner step
    always_comb begin
        case (r_step)
            3'd0: coef = wtss_pkg::T_W'((r_s[3] - r_s[2]) * 50 + (r_s[1] - r_s[4]) * 25
                         + (r_s[5] - r_s[0]) * 5);
            3'd1: coef = wtss_pkg::T_W'(r_s[2] * 126 - r_s[3] * 124 + r_s[4] * 61
                         - r_s[1] * 64 - r_s[5] * 12 + r_s[0] * 13);
            3'd2: coef = wtss_pkg::T_W'(r_s[3] * 66 - r_s[2] * 70 - r_s[4] * 33
                         + r_s[1] * 39 + r_s[5] * 7 - r_s[0] * 9);
            3'd3: coef = wtss_pkg::T_W'((r_s[3] + r_s[1]) * 16 - r_s[0] - r_s[2] * 30
                         - r_s[4]);
            3'd4: coef = wtss_pkg::T_W'((r_s[3] - r_s[1]) * 16 + (r_s[0] - r_s[4]) * 2);
            default: coef = '0;
        endcase
    end

    assign qp    = r_t * $signed({1'b0, r_pf});
    assign t_new = coef + $signed(qp[43:16]);

    // Final gain, offset by the centre word, clamp to 15 bits
    assign kp  = r_t * wtss_pkg::SPLINE_K;
    assign fin = $signed({{9{r_s[2][16]}}, r_s[2]}) + $signed({kp[48], kp[48:24]});
    always_comb begin
        if (fin < 0) begin
            fin_clamp = '0;
        end else if (fin > 26'sd32767) begin
            fin_clamp = 15'h7fff;
        end else begin
            fin_clamp = fin[14:0];
        end
    end

    // Second lookup phase, modulated by the first result in phase mode
    assign morph = (i_cfg.combine_mode == wtss_pkg::CMB_PHASE) ? i_job.z
                                                               : {3'b000, i_job.z[11:3]};
    assign phy   = (i_cfg.combine_mode == wtss_pkg::CMB_PHASE)
                 ? {r_job.yi, 10'b0} + {6'b0, r_xs, 4'b0}
                 : {r_job.yi, 10'b0};

    // Combine the two lookups
    assign prod = r_xs * r_ys;
    assign sum  = {1'b0, r_xs} + {1'b0, r_ys};
    assign dxy  = $signed({1'b0, r_xs}) - $signed({1'b0, r_ys});
    always_comb begin
        case (i_cfg.combine_mode)
            wtss_pkg::CMB_PRODUCT: comb = prod[29:18];
            wtss_pkg::CMB_SUM:     comb = sum[15:4];
            wtss_pkg::CMB_DIFF:    comb = dxy[15:4] + 12'd2048;
            default:               comb = r_ys[14:3];
        endcase
    end

    assign out_free = !r_out_valid || o_out.ready;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_v  <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_READ);
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid && !i_job.is_wr) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_k == 3'd5) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_SPL;
                S_SPL: begin
                    if (r_step == 3'd5) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: r_state <= r_pass ? S_COMB : S_SETY;
                S_SETY: r_state <= S_READ;
                S_COMB: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_k <= r_k;
        r_za   <= za_c;
        r_zb   <= zb_c;
        if (r_rd_v) begin
            r_s[r_rd_k] <= s_new;
        end
        case (r_state)
            S_IDLE: begin
                r_job  <= i_job;
                r_col  <= i_job.xi[14:6];
                r_pf   <= {i_job.xi[5:0], 10'b0};
                r_fam  <= morph[11:10];
                r_mf   <= {morph[9:0], 6'b0};
                r_k    <= '0;
                r_pass <= 1'b0;
            end
            S_READ: r_k <= r_k + 3'd1;
            S_DRAIN: begin
                r_step <= '0;
                r_t    <= '0;
            end
            S_SPL: begin
                r_t    <= t_new;
                r_step <= r_step + 3'd1;
            end
            S_FIN: begin
                if (r_pass) begin
                    r_ys <= fin_clamp;
                end else begin
                    r_xs <= fin_clamp;
                end
            end
            S_SETY: begin
                r_col  <= phy[24:16];
                r_pf   <= phy[15:0];
                r_k    <= '0;
                r_pass <= 1'b1;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_COMB && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_COMB && out_free) begin
            r_sample <= comb;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_sample;

`ifndef ASSERT_OFF
    a_read_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_k <= 3'd5))
        else $error("read counter past last neighbour");
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPL) |-> !r_rd_v)
        else $error("spline started with read data pending");
    a_comb_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMB && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("combined sample not loaded");
`endif

endmodule
